FILE: rtl/mfhtc_pkg.sv
// Shared types and constants for the magnet frame hysteresis turn counter.
package mfhtc_pkg;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int RAW_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int THR_W      = 23;
   localparam int AXIS_W     = 24;
   localparam int TURN_W     = 32;
   localparam int FRAC_W     = 2;
   localparam int CSR_DATA_W = 23;
   localparam int CSR_IDX_W  = 1;

   // Q8.8 gain: fraction bits dropped from the product
   localparam int GAIN_FRAC_W = 8;

   // Reset values of the configuration registers
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
   localparam logic [THR_W-1:0]  THR_RESET  = 23'd30;

   // Default number of magnets on the wheel
   localparam int MAGNETS_PER_TURN_DEF = 3;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Status byte decoding
   localparam logic [BYTE_W-1:0] STATUS_ALL_ONES = 8'hFF;
   localparam int STATUS_ERR_BIT = 3;
   localparam int STATUS_OVF_BIT = 2;
   localparam int STATUS_NEW_BIT = 0;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE_GAIN        = 1'd0,
      CSR_TRIGGER_THRESHOLD = 1'd1
   } csr_index_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_NEW_DATA = 2'd0,
      ST_NO_DATA  = 2'd1,
      ST_COMM_ERR = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_code_type;

   // Byte positions within a response frame
   typedef enum logic [2:0] {
      POS_STATUS = 3'd0,
      POS_X_HI   = 3'd1,
      POS_X_LO   = 3'd2,
      POS_Y_HI   = 3'd3,
      POS_Y_LO   = 3'd4,
      POS_Z_HI   = 3'd5,
      POS_Z_LO   = 3'd6,
      POS_CRC    = 3'd7
   } byte_pos_type;

   // Classified frame handed from front to back
   typedef struct packed {
      status_code_type         code;
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
   } job_type;

   // Frame after the gain multiply
   typedef struct packed {
      status_code_type          code;
      logic signed [AXIS_W-1:0] scaled_x;
      logic signed [AXIS_W-1:0] scaled_y;
      logic signed [AXIS_W-1:0] scaled_z;
   } scaled_type;

endpackage

FILE: rtl/mfhtc_front.sv
// Front end: assembles response bytes into frames and classifies the status byte.
module mfhtc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mfhtc_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                            req_frame_start,
   input  logic                            queue_full,
   output logic                            push,
   output mfhtc_pkg::job_type              push_job
);

   mfhtc_pkg::byte_pos_type           pos_ff, pos_in, pos_eff;
   logic [mfhtc_pkg::BYTE_W-1:0]      status_ff, status_in;
   logic [mfhtc_pkg::RAW_W-1:0]       x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                              accept;
   mfhtc_pkg::status_code_type        code;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Frame start forces the status slot
   assign pos_eff = req_frame_start ? mfhtc_pkg::POS_STATUS : pos_ff;

   // Byte placement and position advance
   always_comb begin
      pos_in    = pos_ff;
      status_in = status_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      if (accept) begin
         pos_in = mfhtc_pkg::byte_pos_type'(3'(pos_eff + 3'd1));
         case (pos_eff)
            mfhtc_pkg::POS_STATUS: status_in = req_rx_byte;
            mfhtc_pkg::POS_X_HI:   x_in = {req_rx_byte, x_ff[7:0]};
            mfhtc_pkg::POS_X_LO:   x_in = {x_ff[15:8], req_rx_byte};
            mfhtc_pkg::POS_Y_HI:   y_in = {req_rx_byte, y_ff[7:0]};
            mfhtc_pkg::POS_Y_LO:   y_in = {y_ff[15:8], req_rx_byte};
            mfhtc_pkg::POS_Z_HI:   z_in = {req_rx_byte, z_ff[7:0]};
            mfhtc_pkg::POS_Z_LO:   z_in = {z_ff[15:8], req_rx_byte};
            default:               pos_in = mfhtc_pkg::POS_STATUS;
         endcase
      end
   end

   // Status classification, communication error first
   always_comb begin
      if (status_ff == mfhtc_pkg::STATUS_ALL_ONES || status_ff[mfhtc_pkg::STATUS_ERR_BIT]) begin
         code = mfhtc_pkg::ST_COMM_ERR;
      end else if (status_ff[mfhtc_pkg::STATUS_OVF_BIT]) begin
         code = mfhtc_pkg::ST_OVERFLOW;
      end else if (status_ff[mfhtc_pkg::STATUS_NEW_BIT]) begin
         code = mfhtc_pkg::ST_NEW_DATA;
      end else begin
         code = mfhtc_pkg::ST_NO_DATA;
      end
   end

   // CRC byte closes the frame
   assign push           = accept && (pos_eff == mfhtc_pkg::POS_CRC);
   assign push_job.code  = code;
   assign push_job.raw_x = $signed(x_ff);
   assign push_job.raw_y = $signed(y_ff);
   assign push_job.raw_z = $signed(z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= mfhtc_pkg::POS_STATUS;
         status_ff <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         z_ff      <= '0;
      end else begin
         pos_ff    <= pos_in;
         status_ff <= status_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
      end
   end

endmodule

FILE: rtl/mfhtc_queue.sv
// Short queue of classified frames between front and back.
module mfhtc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mfhtc_pkg::job_type  push_job,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop,
   output mfhtc_pkg::job_type  pop_job
);

   mfhtc_pkg::job_type                      entry_ff [mfhtc_pkg::QUEUE_DEPTH];
   logic [mfhtc_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mfhtc_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == mfhtc_pkg::QUEUE_CNT_W'(mfhtc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> pop_valid)
      else $error("queue read while empty");

endmodule

FILE: rtl/mfhtc_back.sv
// Back end: gain multiply, Schmitt trigger, pass and turn counters, result register.
module mfhtc_back #(
   parameter int MAGNETS_PER_TURN = mfhtc_pkg::MAGNETS_PER_TURN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mfhtc_pkg::GAIN_W-1:0]         scale_gain,
   input  logic [mfhtc_pkg::THR_W-1:0]          trigger_threshold,
   input  logic                                 pop_valid,
   output logic                                 pop,
   input  mfhtc_pkg::job_type                   pop_job,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status_code,
   output logic signed [mfhtc_pkg::AXIS_W-1:0]  rsp_axis_x,
   output logic signed [mfhtc_pkg::AXIS_W-1:0]  rsp_axis_y,
   output logic signed [mfhtc_pkg::AXIS_W-1:0]  rsp_axis_z,
   output logic                                 rsp_magnet_high,
   output logic [mfhtc_pkg::TURN_W-1:0]         rsp_whole_turns,
   output logic [mfhtc_pkg::FRAC_W-1:0]         rsp_turn_fraction
);

   localparam int PASS_W  = (MAGNETS_PER_TURN > 4) ? $clog2(MAGNETS_PER_TURN) : 2;
   localparam int PROD_W  = mfhtc_pkg::RAW_W + mfhtc_pkg::GAIN_W + 1;
   localparam int AXIS_W  = mfhtc_pkg::AXIS_W;
   localparam int CMP_W   = mfhtc_pkg::AXIS_W + 1;
   localparam int FRAC_LO = mfhtc_pkg::GAIN_FRAC_W;

   // Pipeline stage registers
   logic                    a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   mfhtc_pkg::job_type      a_ff;
   mfhtc_pkg::scaled_type   b_ff, b_in;
   logic                    a_adv, b_adv;

   // Architectural state
   logic signed [AXIS_W-1:0]        hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;
   logic                            trig_ff, trig_in;
   logic [PASS_W-1:0]               pass_ff, pass_in;
   logic [mfhtc_pkg::TURN_W-1:0]    turn_ff, turn_in;

   // Result register
   logic                            out_valid_ff, out_valid_in;
   mfhtc_pkg::status_code_type      out_code_ff;
   logic signed [AXIS_W-1:0]        out_x_ff, out_y_ff, out_z_ff;
   logic                            out_trig_ff;
   logic [mfhtc_pkg::TURN_W-1:0]    out_turn_ff;
   logic [mfhtc_pkg::FRAC_W-1:0]    out_frac_ff;

   logic signed [PROD_W-1:0]        prod_x, prod_y, prod_z, gain_s;
   logic signed [CMP_W-1:0]         z_ext, thr_pos, thr_neg;
   logic                            above, below;

   // Stall chain, result register back to queue
   assign b_adv      = b_valid_ff && (!out_valid_ff || rsp_ready);
   assign a_adv      = a_valid_ff && (!b_valid_ff || b_adv);
   assign pop        = pop_valid && (!a_valid_ff || a_adv);
   assign a_valid_in = pop || (a_valid_ff && !a_adv);
   assign b_valid_in = a_adv || (b_valid_ff && !b_adv);

   // Stage A: Q8.8 gain multiply, floor by arithmetic shift
   assign gain_s = PROD_W'($signed({1'b0, scale_gain}));
   assign prod_x = PROD_W'(a_ff.raw_x) * gain_s;
   assign prod_y = PROD_W'(a_ff.raw_y) * gain_s;
   assign prod_z = PROD_W'(a_ff.raw_z) * gain_s;

   always_comb begin
      b_in.code     = a_ff.code;
      b_in.scaled_x = prod_x[FRAC_LO +: AXIS_W];
      b_in.scaled_y = prod_y[FRAC_LO +: AXIS_W];
      b_in.scaled_z = prod_z[FRAC_LO +: AXIS_W];
   end

   // Stage B: symmetric hysteresis compare on scaled Z
   assign z_ext   = CMP_W'(b_ff.scaled_z);
   assign thr_pos = $signed(CMP_W'(trigger_threshold));
   assign thr_neg = -thr_pos;
   assign above   = z_ext > thr_pos;
   assign below   = z_ext < thr_neg;

   // Commit of a frame: held axes, trigger, counters
   always_comb begin
      hx_in   = hx_ff;
      hy_in   = hy_ff;
      hz_in   = hz_ff;
      trig_in = trig_ff;
      pass_in = pass_ff;
      turn_in = turn_ff;
      if (b_adv && b_ff.code == mfhtc_pkg::ST_NEW_DATA) begin
         hx_in = b_ff.scaled_x;
         hy_in = b_ff.scaled_y;
         hz_in = b_ff.scaled_z;
         if (!trig_ff && above) begin
            trig_in = 1'b1;
         end else if (trig_ff && below) begin
            trig_in = 1'b0;
            if (pass_ff == PASS_W'(MAGNETS_PER_TURN - 1)) begin
               pass_in = '0;
               turn_in = turn_ff + 1'b1;
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end
      end
   end

   assign out_valid_in = b_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (pop) begin
         a_ff <= pop_job;
      end
      if (a_adv) begin
         b_ff <= b_in;
      end
      if (b_adv) begin
         out_code_ff <= b_ff.code;
         out_x_ff    <= hx_in;
         out_y_ff    <= hy_in;
         out_z_ff    <= hz_in;
         out_trig_ff <= trig_in;
         out_turn_ff <= turn_in;
         out_frac_ff <= pass_in[mfhtc_pkg::FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         hx_ff        <= '0;
         hy_ff        <= '0;
         hz_ff        <= '0;
         trig_ff      <= 1'b0;
         pass_ff      <= '0;
         turn_ff      <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         hx_ff        <= hx_in;
         hy_ff        <= hy_in;
         hz_ff        <= hz_in;
         trig_ff      <= trig_in;
         pass_ff      <= pass_in;
         turn_ff      <= turn_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status_code   = out_code_ff;
   assign rsp_axis_x        = out_x_ff;
   assign rsp_axis_y        = out_y_ff;
   assign rsp_axis_z        = out_z_ff;
   assign rsp_magnet_high   = out_trig_ff;
   assign rsp_whole_turns   = out_turn_ff;
   assign rsp_turn_fraction = out_frac_ff;

   a_pass_range: assert property (@(posedge clock) disable iff (reset)
      int'(pass_ff) < MAGNETS_PER_TURN)
      else $error("pass count reached a full turn");
   a_state_idle: assert property (@(posedge clock) disable iff (reset)
      !b_adv |=> $stable(trig_ff) && $stable(turn_ff) && $stable(pass_ff))
      else $error("trigger or counters moved without a committed frame");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(b_adv))
      else $error("result appeared without a committed frame");

endmodule

FILE: rtl/magnet_frame_hysteresis_turn_counter.sv
// Top level: configuration registers and the front, queue and back of the turn counter.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_rx_byte, req_frame_start
//  rsp      out  rsp_valid/rsp_ready    status, three axes, magnet_high, turns, fraction
//  csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
//  One byte is taken per cycle; req_ready drops only with the queue full. The CRC byte of
//  a frame yields one result, registered in turn in the queue, gain multiply stage, trigger
//  and counter stage and result register. The back end takes one frame per cycle unless
//  a result waits on rsp_ready, and the two-entry queue lets the front keep taking bytes.
//  Reset is synchronous and clears position, counters, trigger and held axes; gain
//  returns to 1.0 and threshold to 30. The csr channel is always ready.
module magnet_frame_hysteresis_turn_counter #(
   parameter int MAGNETS_PER_TURN = mfhtc_pkg::MAGNETS_PER_TURN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mfhtc_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status_code,
   output logic signed [mfhtc_pkg::AXIS_W-1:0]   rsp_axis_x,
   output logic signed [mfhtc_pkg::AXIS_W-1:0]   rsp_axis_y,
   output logic signed [mfhtc_pkg::AXIS_W-1:0]   rsp_axis_z,
   output logic                                  rsp_magnet_high,
   output logic [mfhtc_pkg::TURN_W-1:0]          rsp_whole_turns,
   output logic [mfhtc_pkg::FRAC_W-1:0]          rsp_turn_fraction,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mfhtc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfhtc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [mfhtc_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic [mfhtc_pkg::THR_W-1:0]   thr_ff, thr_in;
   logic                          queue_full, push, pop, pop_valid;
   mfhtc_pkg::job_type            push_job, pop_job;

   assign csr_ready = 1'b1;

   // Configuration register writes
   always_comb begin
      gain_in = gain_ff;
      thr_in  = thr_ff;
      if (csr_valid && csr_ready) begin
         case (mfhtc_pkg::csr_index_type'(csr_index))
            mfhtc_pkg::CSR_SCALE_GAIN:        gain_in = csr_wdata[mfhtc_pkg::GAIN_W-1:0];
            mfhtc_pkg::CSR_TRIGGER_THRESHOLD: thr_in  = csr_wdata[mfhtc_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= mfhtc_pkg::GAIN_RESET;
         thr_ff  <= mfhtc_pkg::THR_RESET;
      end else begin
         gain_ff <= gain_in;
         thr_ff  <= thr_in;
      end
   end

   mfhtc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   mfhtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_job   (pop_job)
   );

   mfhtc_back #(
      .MAGNETS_PER_TURN (MAGNETS_PER_TURN)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .scale_gain        (gain_ff),
      .trigger_threshold (thr_ff),
      .pop_valid         (pop_valid),
      .pop               (pop),
      .pop_job           (pop_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status_code   (rsp_status_code),
      .rsp_axis_x        (rsp_axis_x),
      .rsp_axis_y        (rsp_axis_y),
      .rsp_axis_z        (rsp_axis_z),
      .rsp_magnet_high   (rsp_magnet_high),
      .rsp_whole_turns   (rsp_whole_turns),
      .rsp_turn_fraction (rsp_turn_fraction)
   );

endmodule
